### rtl/pidaw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types, register indexes and saturation helpers for the PID block.
// ----------------------------------------------------------------------------
package pidaw_pkg;

    localparam int CfgIdxW   = 3;
    localparam int DivSteps  = 64;
    localparam int DivCntW   = $clog2(DivSteps + 1);

    typedef enum logic [CfgIdxW-1:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_INT_LIMIT = 3'd3,
        REG_OUT_LIMIT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] m, input logic neg);
        logic [31:0] r;
        if (neg)
        begin
            r = (m > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
        end
        else
        begin
            r = (m > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] sat64(input logic [63:0] m, input logic neg);
        logic [63:0] r;
        if (neg)
        begin
            r = 64'd0 - m;
        end
        else
        begin
            r = m[63] ? 64'h7FFF_FFFF_FFFF_FFFF : m;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/pidaw_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidaw_in_if
// Input channel: one control step request per transaction.
// ----------------------------------------------------------------------------
interface pidaw_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] setpoint;
    logic signed [31:0] measurement;
    logic [23:0]        step_time;

    modport source (output valid, mode, setpoint, measurement, step_time, input ready);
    modport sink   (input valid, mode, setpoint, measurement, step_time, output ready);
endinterface
`default_nettype wire

### rtl/pidaw_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidaw_out_if
// Output channel: drive and the three terms, one result per transaction.
// ----------------------------------------------------------------------------
interface pidaw_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic signed [31:0] prop_term;
    logic signed [31:0] integ_term;
    logic signed [31:0] deriv_term;

    modport source (output valid, drive, prop_term, integ_term, deriv_term, input ready);
    modport sink   (input valid, drive, prop_term, integ_term, deriv_term, output ready);
endinterface
`default_nettype wire

### rtl/pid_controller_antiwindup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// PID step, derivative on measurement, integral clamp with back-calculation.
// ----------------------------------------------------------------------------
// One transaction at a time. A run step adds a division for the integrator
// back-calculation when the integral clamp acts with nonzero gain_i, and a
// division and derivative multiply for the measurement rate when not the
// first step and step_time is nonzero; a clear skips the arithmetic.
// Run step length is set by the bit-serial divider and the single shared
// multiplier. The result is held until taken; no new input meanwhile.
module pid_controller_antiwindup (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pidaw_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [31:0]                      cfg_data,
    pidaw_in_if.sink                              in_ch,
    pidaw_out_if.source                           out_ch
);
    import pidaw_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_ERR   = 14'b00000000000010,
        S_MP    = 14'b00000000000100,
        S_MI    = 14'b00000000001000,
        S_ACC   = 14'b00000000010000,
        S_MK1   = 14'b00000000100000,
        S_MK2   = 14'b00000001000000,
        S_MK3   = 14'b00000010000000,
        S_DIVB  = 14'b00000100000000,
        S_DST   = 14'b00001000000000,
        S_DIVD  = 14'b00010000000000,
        S_MD    = 14'b00100000000000,
        S_SUM   = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] kp_reg, ki_reg, kd_reg;
    logic [30:0] ilim_reg, olim_reg;
    logic [63:0] integ_reg;
    logic [31:0] last_reg;
    logic        first_reg;
    logic        outv_reg;

    logic [31:0] sp_reg, ms_reg;
    logic [23:0] dt_reg;
    logic [31:0] err_reg, p_reg, it_reg, d_reg, rate_reg;
    logic [63:0] acc_reg;
    logic        bneg_reg;
    logic [31:0] drive_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    div_req_t    dreq;
    div_rsp_t    drsp;

    logic [32:0] ediff;
    logic [31:0] err_sat, err_mag, ki_mag, it_mag;
    logic [63:0] im, inc, acc;
    logic [64:0] isum;
    logic [31:0] raw;
    logic [32:0] raw_x, lim_x, it_x;
    logic [32:0] mdiff, mdiff_mag;
    logic [31:0] rate_new;
    logic [33:0] sum, olim_x;
    logic [31:0] drive_new;

    pidaw_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(prod));
    pidaw_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_comb
    begin
        ediff   = {sp_reg[31], sp_reg} - {ms_reg[31], ms_reg};
        err_sat = (ediff[32] != ediff[31]) ? (ediff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                           : ediff[31:0];
        err_mag = mag32(err_reg);
        ki_mag  = mag32(ki_reg);
        im      = mag64(integ_reg);

        inc  = err_reg[31] ? (64'd0 - (prod >> 8)) : (prod >> 8);
        isum = {integ_reg[63], integ_reg} + {inc[63], inc};

        acc   = acc_reg + {32'd0, prod[63:32]};
        raw   = sat32(acc, ki_reg[31] ^ integ_reg[63]);
        raw_x = {raw[31], raw};
        lim_x = {2'b00, ilim_reg};
        if ($signed(raw_x) > $signed(lim_x))
            it_x = lim_x;
        else if ($signed(raw_x) < -$signed(lim_x))
            it_x = 33'd0 - lim_x;
        else
            it_x = raw_x;
        it_mag = mag32(it_x[31:0]);

        mdiff     = {ms_reg[31], ms_reg} - {last_reg[31], last_reg};
        mdiff_mag = mdiff[32] ? (33'd0 - mdiff) : mdiff;
        rate_new  = sat32(drsp.quotient, bneg_reg);

        sum    = {{2{p_reg[31]}}, p_reg} + {{2{it_reg[31]}}, it_reg}
               + {{2{d_reg[31]}}, d_reg};
        olim_x = {3'b000, olim_reg};
        if ($signed(sum) > $signed(olim_x))
            drive_new = olim_x[31:0];
        else if ($signed(sum) < -$signed(olim_x))
            drive_new = 32'(34'd0 - olim_x);
        else
            drive_new = sum[31:0];

        case (state_reg)
            S_MI:    begin mul_a = err_mag;  mul_b = {8'd0, dt_reg}; end
            S_MK1:   begin mul_a = ki_mag;   mul_b = im[63:32]; end
            S_MK2:   begin mul_a = ki_mag;   mul_b = im[31:0]; end
            S_DIVD:  begin mul_a = mag32(kd_reg); mul_b = mag32(rate_new); end
            default: begin mul_a = mag32(kp_reg); mul_b = err_mag; end
        endcase

        dreq.start    = 1'b0;
        dreq.dividend = {it_mag, 32'd0};
        dreq.divisor  = ki_mag;
        if (state_reg == S_MK3)
            dreq.start = (raw_x != it_x) && (ki_reg != 32'd0);
        else if (state_reg == S_DST)
        begin
            dreq.start    = !first_reg && (dt_reg != 24'd0);
            dreq.dividend = {7'd0, mdiff_mag, 24'd0};
            dreq.divisor  = {8'd0, dt_reg};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_ch.valid) state_next = in_ch.mode ? S_OUT : S_ERR;
            S_ERR:   state_next = S_MP;
            S_MP:    state_next = S_MI;
            S_MI:    state_next = S_ACC;
            S_ACC:   state_next = S_MK1;
            S_MK1:   state_next = S_MK2;
            S_MK2:   state_next = S_MK3;
            S_MK3:   state_next = dreq.start ? S_DIVB : S_DST;
            S_DIVB:  if (drsp.done) state_next = S_DST;
            S_DST:   state_next = dreq.start ? S_DIVD : S_SUM;
            S_DIVD:  if (drsp.done) state_next = S_MD;
            S_MD:    state_next = S_SUM;
            S_SUM:   state_next = S_OUT;
            S_OUT:   if (out_ch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kp_reg    <= '0;
            ki_reg    <= '0;
            kd_reg    <= '0;
            ilim_reg  <= '0;
            olim_reg  <= '0;
            integ_reg <= '0;
            last_reg  <= '0;
            first_reg <= 1'b1;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN_P:    kp_reg   <= cfg_data;
                    REG_GAIN_I:    ki_reg   <= cfg_data;
                    REG_GAIN_D:    kd_reg   <= cfg_data;
                    REG_INT_LIMIT: ilim_reg <= cfg_data[30:0];
                    REG_OUT_LIMIT: olim_reg <= cfg_data[30:0];
                    default:       ;
                endcase
            end
            if (state_reg == S_IDLE && in_ch.valid)
            begin
                if (in_ch.mode)
                begin
                    integ_reg <= '0;
                    last_reg  <= '0;
                    first_reg <= 1'b1;
                    outv_reg  <= 1'b1;
                end
            end
            if (state_reg == S_ACC)
                integ_reg <= (isum[64] != isum[63])
                           ? (isum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                           : isum[63:0];
            if (state_reg == S_DIVB && drsp.done)
                integ_reg <= sat64(drsp.quotient, bneg_reg);
            if (state_reg == S_SUM)
            begin
                last_reg  <= ms_reg;
                first_reg <= 1'b0;
                outv_reg  <= 1'b1;
            end
            if (state_reg == S_OUT && out_ch.ready)
                outv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                sp_reg    <= in_ch.setpoint;
                ms_reg    <= in_ch.measurement;
                dt_reg    <= in_ch.step_time;
                p_reg     <= '0;
                it_reg    <= '0;
                d_reg     <= '0;
                drive_reg <= '0;
            end
            S_ERR:  err_reg <= err_sat;
            S_MI:   p_reg   <= sat32(prod >> 16, kp_reg[31] ^ err_reg[31]);
            S_MK2:  acc_reg <= prod;
            S_MK3:
            begin
                it_reg   <= it_x[31:0];
                bneg_reg <= it_x[32] ^ ki_reg[31];
            end
            S_DST:  bneg_reg <= mdiff[32];
            S_DIVD: rate_reg <= rate_new;
            S_MD:   d_reg    <= sat32(prod >> 16, kd_reg[31] == rate_reg[31]);
            S_SUM:  drive_reg <= drive_new;
            default: ;
        endcase
    end

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = outv_reg && (state_reg == S_OUT);
    assign out_ch.drive      = drive_reg;
    assign out_ch.prop_term  = p_reg;
    assign out_ch.integ_term = it_reg;
    assign out_ch.deriv_term = d_reg;
endmodule
`default_nettype wire

### rtl/pidaw_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidaw_mul
// Shared 32x32 unsigned multiplier, product registered.
// ----------------------------------------------------------------------------
module pidaw_mul (
    input  wire logic        clk,
    input  wire logic [31:0] op_a,
    input  wire logic [31:0] op_b,
    output logic      [63:0] prod
);
    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= {32'd0, op_a} * {32'd0, op_b};
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire

### rtl/pidaw_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidaw_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module pidaw_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pidaw_pkg::div_req_t req,
    output pidaw_pkg::div_rsp_t      rsp
);
    import pidaw_pkg::*;

    logic [63:0]        quo_reg, quo_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        dsr_reg;
    logic [DivCntW-1:0] cnt_reg;
    logic               busy_reg, done_reg;
    logic [32:0]        rem_sh;
    logic               ge;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[63]};
        ge       = rem_sh >= {1'b0, dsr_reg};
        rem_next = ge ? 32'(rem_sh - {1'b0, dsr_reg}) : rem_sh[31:0];
        quo_next = {quo_reg[62:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DivCntW'(DivSteps);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DivCntW'(1);
                if (cnt_reg == DivCntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire
